// File: rtl/point_to_line_distance_assert.svh
// Assertion macros for the point-to-line distance block.
// Included by modules that check their own pipeline logic; no other dependencies.
`ifndef POINT_TO_LINE_DISTANCE_ASSERT_SVH
`define POINT_TO_LINE_DISTANCE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pld_pkg.sv
// Package for the point-to-line distance block: result widths and constants.
// No dependencies.
`timescale 1ns / 1ps

package pld_pkg;

    // Result width and its saturation value
    localparam int DIST_BITS = 17;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // One root stage per result bit, plus one that detects saturation
    localparam int ROOT_STEPS = DIST_BITS + 1;

    // Front stages: differences, products, len2/cross, cross squared
    localparam int FRONT_STAGES = 4;

endpackage

// File: rtl/point_to_line_distance.sv
// Point-to-line distance: fully pipelined, one item per cycle unless the output stalls.
// Depends on pld_pkg and point_to_line_distance_assert.svh.
//
// Takes line points A, B and query point Q (signed, 1/16 pixel) and returns
// floor(|cross(B-A, Q-A)| / |B-A|) in 1/16 pixel, saturated to 17 bits. A
// degenerate line (A equal to B) gives distance 0 with tuser set. The block
// accepts one item per clock unless the output stalls, passing it through 4
// front stages (differences, products, len2/cross, cross squared) and 18
// restoring root-division stages, one per result bit plus a saturation test.
// Each stage holds while the next one is full, so bubbles close up under stall.
`timescale 1ns / 1ps
`include "point_to_line_distance_assert.svh"

module point_to_line_distance #(
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // fields from bit 0: line_ax, line_ay, line_bx, line_by, query_x, query_y
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // fields from bit 0: distance
    output logic [23:0]                       m_axis_tdata,
    // fields from bit 0: degenerate
    output logic                              m_axis_tuser
);

    localparam int W     = COORD_BITS;
    localparam int DW    = W + 1;               // coordinate difference
    localparam int PW    = 2 * DW;              // product
    localparam int LW    = 2 * W + 1;           // len2 and |cross|
    localparam int C2W   = 2 * LW;              // cross squared
    localparam int DB    = pld_pkg::DIST_BITS;
    localparam int NSTEP = pld_pkg::ROOT_STEPS;
    localparam int RW_A  = C2W + 2;
    localparam int RW_B  = LW + 2 * DB + 2;
    localparam int RW    = (RW_A > RW_B) ? RW_A : RW_B;
    localparam int NS    = pld_pkg::FRONT_STAGES + NSTEP;

    // Pipeline valid bits and load enables
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] load;

    always_comb
    begin
        load[NS-1] = ~valid_reg[NS-1] | m_axis_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            load[i] = ~valid_reg[i] | load[i+1];
        end
    end

    assign s_axis_tready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Input field split
    logic signed [W-1:0] ax, ay, bx, by, qx, qy;
    assign ax = s_axis_tdata[0*W +: W];
    assign ay = s_axis_tdata[1*W +: W];
    assign bx = s_axis_tdata[2*W +: W];
    assign by = s_axis_tdata[3*W +: W];
    assign qx = s_axis_tdata[4*W +: W];
    assign qy = s_axis_tdata[5*W +: W];

    // Stage 0: differences
    logic signed [DW-1:0] dxl_reg, dyl_reg, dxq_reg, dyq_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            dxl_reg <= DW'(bx) - DW'(ax);
            dyl_reg <= DW'(by) - DW'(ay);
            dxq_reg <= DW'(qx) - DW'(ax);
            dyq_reg <= DW'(qy) - DW'(ay);
        end
    end

    // Stage 1: four products
    logic signed [PW-1:0] sxx_reg, syy_reg, sxq_reg, syq_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            sxx_reg <= dxl_reg * dxl_reg;
            syy_reg <= dyl_reg * dyl_reg;
            sxq_reg <= dxl_reg * dyq_reg;
            syq_reg <= dyl_reg * dxq_reg;
        end
    end

    // Stage 2: len2, |cross|, degenerate flag
    logic signed [PW:0] len2_full, cross_full;
    logic [LW-1:0]      len2_reg, cmag_reg;
    logic               degen_reg;

    assign len2_full  = (PW+1)'(sxx_reg) + (PW+1)'(syy_reg);
    assign cross_full = (PW+1)'(sxq_reg) - (PW+1)'(syq_reg);

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            len2_reg  <= LW'(len2_full);
            cmag_reg  <= cross_full[PW] ? LW'(-cross_full) : LW'(cross_full);
            degen_reg <= (len2_full == '0);
        end
    end

    // Stage 3 and root steps: remainder, running d*len2, partial result
    logic [RW-1:0] rem_reg   [0:NSTEP];
    logic [RW-1:0] prod_reg  [0:NSTEP];
    logic [DB:0]   root_reg  [0:NSTEP];
    logic [LW-1:0] len_reg   [0:NSTEP];
    logic          dg_reg    [0:NSTEP];
    logic [C2W-1:0] c2_full;

    // Full-width cross squared
    assign c2_full = cmag_reg * cmag_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            rem_reg[0]  <= RW'(c2_full);
            prod_reg[0] <= '0;
            root_reg[0] <= '0;
            len_reg[0]  <= len2_reg;
            dg_reg[0]   <= degen_reg;
        end
    end

    // Restoring root-division: step k tries bit DB-k of the result
    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        localparam int B = DB - k;
        logic [RW-1:0] term;
        logic          fits;

        assign term = (prod_reg[k] << (B + 1)) + (RW'(len_reg[k]) << (2 * B));
        assign fits = (term <= rem_reg[k]);

        always_ff @(posedge clk)
        begin
            if (load[pld_pkg::FRONT_STAGES + k])
            begin
                rem_reg[k+1]  <= fits ? rem_reg[k] - term : rem_reg[k];
                prod_reg[k+1] <= fits ? prod_reg[k] + (RW'(len_reg[k]) << B)
                                      : prod_reg[k];
                root_reg[k+1] <= fits ? root_reg[k] | ((DB+1)'(1) << B) : root_reg[k];
                len_reg[k+1]  <= len_reg[k];
                dg_reg[k+1]   <= dg_reg[k];
            end
        end
    end

    // Output: saturate, force zero on a degenerate line
    logic [DB-1:0] dist_out;

    always_comb
    begin
        if (dg_reg[NSTEP])
        begin
            dist_out = '0;
        end
        else if (root_reg[NSTEP][DB])
        begin
            dist_out = pld_pkg::DIST_MAX;
        end
        else
        begin
            dist_out = root_reg[NSTEP][DB-1:0];
        end
    end

    assign m_axis_tvalid = valid_reg[NS-1];
    assign m_axis_tdata  = 24'(dist_out);
    assign m_axis_tuser  = dg_reg[NSTEP];

    // Checks
    `PLD_ASSERT_NOW(a_degen_zero, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == '0, "degenerate item with nonzero distance")
    `PLD_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready,
        "input stalled while output stage empty")
    `PLD_ASSERT_NOW(a_degen_cross, valid_reg[3] && dg_reg[0], rem_reg[0] == '0,
        "coincident points gave nonzero cross")
    `PLD_ASSERT_NEXT(a_stall_hold, valid_reg[NS-1] && !m_axis_tready, valid_reg[NS-1],
        "held result dropped")

endmodule
